FILE: design/ksl_pkg.sv
`default_nettype none
package ksl_pkg;

  localparam int KEY_BITS     = 31;
  localparam int PAYLOAD_BITS = 32;

  // operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_SCAN   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_END       = 2'd3;

  typedef struct packed {
    logic [1:0]              operation;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [KEY_BITS-1:0]     found_key;
    logic [PAYLOAD_BITS-1:0] found_payload;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // take the request into the item register
    logic sweep;     // write an empty slot at the walk address, step
    logic clr_done;  // clear finished: rewind scan pointer, result ok
    logic walk;      // read the slot at the walk address, step
    logic finish;    // walk resolved: update slot, pointer, result
    logic load_out;  // move result into the response register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sweep_last;
    logic hit;
    logic miss;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/ksl_ctrl.sv
`default_nettype none
module ksl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  input  wire logic [1:0]    op,
  output logic               req_ready,
  input  wire ksl_pkg::sts_t sts,
  output ksl_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SWEEP = 5'b00100,
    S_WALK  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = (op == ksl_pkg::OP_CLEAR) ? S_SWEEP : S_WALK;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          cmd.clr_done = 1'b1;
          state_next   = S_RESP;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.hit || sts.miss) begin
          cmd.finish = 1'b1;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/ksl_dp.sv
`default_nettype none
module ksl_dp #(
  parameter int SLOTS = 512
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ksl_pkg::req_t req_data,
  input  wire ksl_pkg::cmd_t cmd,
  output ksl_pkg::sts_t      sts,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output ksl_pkg::rsp_t      rsp_data
);

  localparam int KB = ksl_pkg::KEY_BITS;
  localparam int PB = ksl_pkg::PAYLOAD_BITS;
  localparam int W  = 1 + KB + PB;
  localparam int AW = $clog2(SLOTS + 1);
  localparam int IW = $clog2(SLOTS);
  localparam logic [AW-1:0] ADDR_END  = AW'(SLOTS);
  localparam logic [AW-1:0] ADDR_LAST = AW'(SLOTS - 1);
  localparam logic [IW-1:0] IDX_LAST  = IW'(SLOTS - 1);

  // slot word: {valid, key, payload}
  logic [W-1:0]    mem [SLOTS];
  logic [W-1:0]    rd_word;
  logic            wr_en;
  logic [IW-1:0]   wr_idx;
  logic [W-1:0]    wr_word;

  ksl_pkg::req_t   item;
  logic [AW-1:0]   addr;
  logic [AW-1:0]   scan_ptr;
  logic            chk_valid;
  logic [IW-1:0]   chk_idx;
  logic            issue;
  logic            match;
  logic            rd_vld;
  logic [KB-1:0]   rd_key;
  logic [PB-1:0]   rd_pay;
  ksl_pkg::rsp_t   res;
  ksl_pkg::rsp_t   res_next;

  assign rd_vld = rd_word[W-1];
  assign rd_key = rd_word[W-2 -: KB];
  assign rd_pay = rd_word[PB-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_word;
    end
    rd_word <= mem[addr[IW-1:0]];
  end

  assign issue = cmd.walk && (addr != ADDR_END);

  always_comb begin
    case (item.operation)
      ksl_pkg::OP_INSERT: match = !rd_vld;
      ksl_pkg::OP_REMOVE: match = rd_vld && (rd_key == item.key);
      ksl_pkg::OP_SCAN:   match = rd_vld;
      default:            match = 1'b0;
    endcase
  end

  always_comb begin
    sts.sweep_last = (addr == ADDR_LAST);
    sts.hit        = chk_valid && match;
    sts.miss       = !(chk_valid && match) &&
                     (chk_valid ? (chk_idx == IDX_LAST) : (addr == ADDR_END));
    sts.out_busy   = rsp_valid && !rsp_ready;
  end

  // slot writes: empty during a sweep, fill on insert, free on remove
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = addr[IW-1:0];
    wr_word = '0;
    if (cmd.sweep) begin
      wr_en = 1'b1;
    end else if (cmd.finish && sts.hit) begin
      wr_idx = chk_idx;
      if (item.operation == ksl_pkg::OP_INSERT) begin
        wr_en   = 1'b1;
        wr_word = {1'b1, item.key, item.payload};
      end else if (item.operation == ksl_pkg::OP_REMOVE) begin
        wr_en   = 1'b1;
        wr_word = {1'b0, rd_key, rd_pay};
      end
    end
  end

  // result of the resolved walk; clear always reports ok
  always_comb begin
    res_next = '{status: ksl_pkg::ST_OK, found_key: '0, found_payload: '0};
    case (item.operation)
      ksl_pkg::OP_INSERT: begin
        if (!sts.hit) begin
          res_next.status = ksl_pkg::ST_FULL;
        end
      end
      ksl_pkg::OP_REMOVE: begin
        if (sts.hit) begin
          res_next.found_payload = rd_pay;
        end else begin
          res_next.status = ksl_pkg::ST_NOT_FOUND;
        end
      end
      ksl_pkg::OP_SCAN: begin
        if (sts.hit) begin
          res_next.found_key     = rd_key;
          res_next.found_payload = rd_pay;
        end else begin
          res_next.status = ksl_pkg::ST_END;
        end
      end
      default: begin
        res_next.status = ksl_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr      <= '0;
      scan_ptr  <= '0;
      chk_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      chk_valid <= issue;
      if (cmd.accept) begin
        addr <= (req_data.operation == ksl_pkg::OP_SCAN) ? scan_ptr : '0;
      end else if (cmd.sweep || issue) begin
        addr <= addr + AW'(1);
      end
      if (cmd.clr_done) begin
        scan_ptr <= '0;
      end else if (cmd.finish && item.operation == ksl_pkg::OP_SCAN) begin
        scan_ptr <= sts.hit ? (AW'(chk_idx) + AW'(1)) : '0;
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= addr[IW-1:0];
    if (cmd.accept) begin
      item <= req_data;
    end
    if (cmd.clr_done || cmd.finish) begin
      res <= res_next;
    end
    if (cmd.load_out) begin
      rsp_data <= res;
    end
  end

endmodule
`default_nettype wire

FILE: design/keyed_slot_table.sv
`default_nettype none
// channel | signals                        | direction | payload
// req     | req_valid, req_ready, req_data | in        | operation, key, payload
// rsp     | rsp_valid, rsp_ready, rsp_data | out       | status, found_key, found_payload
//
// One transaction at a time. The walk reads one slot per cycle from the slot
// memory and stops at the slot where the transaction resolves or at the last
// slot. Clear sweeps all SLOTS entries. After reset a clearing pass over all
// SLOTS slots runs before req_ready rises.
// A response stalled on rsp_ready holds in its register; the next request is
// taken meanwhile and its result waits until the response register frees up.
module keyed_slot_table #(
  parameter int SLOTS = 512
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire ksl_pkg::req_t req_data,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output ksl_pkg::rsp_t      rsp_data
);

  ksl_pkg::cmd_t cmd;
  ksl_pkg::sts_t sts;

  // sequencer: init sweep, accept, sweep or walk, respond
  ksl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .op        (req_data.operation),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // slot memory, walk address, scan pointer, result and response registers
  ksl_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  // one transaction in flight: no request taken right after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted back to back");

  // a walk never reports both outcomes
  a_hit_miss_excl: assert property (@(posedge clk) disable iff (rst)
    !(sts.hit && sts.miss))
    else $error("walk reports hit and miss together");

  // only a successful transaction carries data
  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status != ksl_pkg::ST_OK) |->
      (rsp_data.found_key == '0 && rsp_data.found_payload == '0))
    else $error("failed response carries data");

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;
  import ksl_pkg::*;

  localparam int SLOTS       = 512;
  localparam int KEY_POOL    = 8;       // small key pool so duplicates show up
  localparam int LIVE_CAP    = 48;      // keep random occupancy low, walks stay short
  localparam int DRAIN_LIMIT = 200000;  // cycles allowed for the last results
  localparam logic [KEY_BITS-1:0]     KEY_MAX = '1;
  localparam logic [PAYLOAD_BITS-1:0] PAY_MAX = '1;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data  = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  keyed_slot_table #(.SLOTS(SLOTS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the slot table. Only valid slots are ever read, so the
  // key/payload arrays need no reset.
  // ---------------------------------------------------------------------------
  logic                    slot_used [SLOTS];
  logic [KEY_BITS-1:0]     slot_key  [SLOTS];
  logic [PAYLOAD_BITS-1:0] slot_pay  [SLOTS];
  int                      scan_ptr;    // 0..SLOTS
  int                      occupancy;   // number of valid slots

  rsp_t expected_rsp [$];   // results owed by the block, oldest first
  int   mismatch_count = 0;
  int   items_sent     = 0;

  // idling knobs, read by the driver and the receiver
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_len       = 0;   // long receiver hold-off, counted down per cycle

  // Apply one transaction to the shadow table and return the result it owes.
  function automatic rsp_t table_apply(req_t r);
    rsp_t res;
    bit   done;
    res  = '0;
    done = 1'b0;
    case (r.operation)
      OP_CLEAR: begin
        // only valid bits and the pointer change; stale keys stay behind
        for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
        scan_ptr   = 0;
        occupancy  = 0;
        res.status = ST_OK;
      end
      OP_INSERT: begin
        res.status = ST_FULL;
        for (int i = 0; i < SLOTS && !done; i++) begin
          if (!slot_used[i]) begin
            slot_used[i] = 1'b1;
            slot_key[i]  = r.key;
            slot_pay[i]  = r.payload;
            occupancy++;
            res.status   = ST_OK;
            done         = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        // lowest matching slot wins when a key is duplicated
        res.status = ST_NOT_FOUND;
        for (int i = 0; i < SLOTS && !done; i++) begin
          if (slot_used[i] && slot_key[i] == r.key) begin
            slot_used[i]      = 1'b0;
            occupancy--;
            res.status        = ST_OK;
            res.found_payload = slot_pay[i];
            done              = 1'b1;
          end
        end
      end
      OP_SCAN: begin
        for (int i = scan_ptr; i < SLOTS && !done; i++) begin
          if (slot_used[i]) begin
            scan_ptr          = i + 1;
            res.status        = ST_OK;
            res.found_key     = slot_key[i];
            res.found_payload = slot_pay[i];
            done              = 1'b1;
          end
        end
        // nothing left past the pointer: report end and rewind
        if (!done) begin
          scan_ptr   = 0;
          res.status = ST_END;
        end
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Inputs move on the falling edge; the transaction is taken
  // at the first rising edge with req_ready high. Valid is held, payload
  // stable, until then; an idle gap only ever starts after an acceptance.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] op, input logic [KEY_BITS-1:0] key,
                           input logic [PAYLOAD_BITS-1:0] pay);
    req_t r;
    r.operation = op;
    r.key       = key;
    r.payload   = pay;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
    expected_rsp.push_back(table_apply(r));
    items_sent++;
  endtask

  // Drop valid so the last transaction is not taken twice.
  task automatic release_req();
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  // Key source: small pool for duplicates, the extremes, and fully random.
  function automatic logic [KEY_BITS-1:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return KEY_BITS'($urandom_range(KEY_POOL - 1));
    if (sel < 45) return '0;
    if (sel < 50) return KEY_MAX;
    return KEY_BITS'($urandom);
  endfunction

  // Key of a random live slot, so a remove usually hits.
  function automatic logic [KEY_BITS-1:0] pick_live_key();
    int n;
    if (occupancy == 0) return pick_key();
    n = $urandom_range(occupancy - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i]) begin
        if (n == 0) return slot_key[i];
        n--;
      end
    end
    return pick_key();
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: random stalls, plus a long hold-off when hold_len is set.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_len > 0) begin
      rsp_ready <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: every accepted response against the oldest expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        $error("response with nothing expected: status %0d key %0h payload %0h",
               rsp_data.status, rsp_data.found_key, rsp_data.found_payload);
        mismatch_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
          mismatch_count++;
        end
        if (rsp_data.found_key !== want.found_key) begin
          $error("found_key: expected %0h, actual %0h",
                 want.found_key, rsp_data.found_key);
          mismatch_count++;
        end
        if (rsp_data.found_payload !== want.found_payload) begin
          $error("found_payload: expected %0h, actual %0h",
                 want.found_payload, rsp_data.found_payload);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every operation, duplicates, scan with inserts/removes
  // behind and at the pointer, clear with stale contents.
  task automatic test_directed();
    send_item(OP_SCAN,   '0, '0);                     // empty table: end
    send_item(OP_REMOVE, 31'd5, '0);                  // empty table: not found
    send_item(OP_INSERT, '0, '0);                     // slot 0
    send_item(OP_INSERT, KEY_MAX, PAY_MAX);           // slot 1
    send_item(OP_INSERT, KEY_MAX, 32'h5A5A_5A5A);     // slot 2, duplicate key
    send_item(OP_INSERT, 31'h2AAA_AAAA, 32'hA5A5_A5A5);
    send_item(OP_SCAN,   '0, '0);                     // slot 0, pointer to 1
    send_item(OP_REMOVE, KEY_MAX, '0);                // lowest duplicate goes
    send_item(OP_INSERT, 31'h0123_4567, 32'h0F0F_0F0F); // lands at the pointer
    send_item(OP_REMOVE, '0, '0);                     // frees slot behind pointer
    send_item(OP_INSERT, 31'd77, 32'hFFFF_0000);      // behind pointer, unseen
    send_item(OP_SCAN,   '0, '0);
    send_item(OP_SCAN,   '0, '0);
    send_item(OP_SCAN,   '0, '0);
    send_item(OP_SCAN,   '0, '0);                     // end, rewind
    send_item(OP_SCAN,   '0, '0);                     // now sees key 77
    send_item(OP_REMOVE, KEY_MAX, '0);                // second duplicate
    send_item(OP_REMOVE, KEY_MAX, '0);                // gone: not found
    send_item(OP_CLEAR,  KEY_MAX, PAY_MAX);           // key/payload ignored
    send_item(OP_SCAN,   '0, '0);
    send_item(OP_REMOVE, 31'd77, '0);                 // stale key must not match
    send_item(OP_INSERT, 31'h5555_5555, 32'h0000_FFFF);
    send_item(OP_SCAN,   '0, '0);
    send_item(OP_CLEAR,  '0, '0);
  endtask

  // Receiver holds off long enough that the output register and the
  // internal result both fill and req_ready drops while requests wait.
  task automatic test_backpressure();
    hold_len = 3000;
    for (int i = 0; i < 8; i++) send_item(OP_INSERT, pick_key(), $urandom);
    send_item(OP_SCAN, '0, '0);
    send_item(OP_SCAN, '0, '0);
  endtask

  // Fill every slot, overflow a few times, punch holes and refill them.
  task automatic test_full_table();
    send_item(OP_CLEAR, '0, '0);
    for (int i = 0; i < SLOTS + 3; i++) send_item(OP_INSERT, pick_key(), $urandom);
    for (int i = 0; i < 4; i++) send_item(OP_REMOVE, pick_live_key(), '0);
    for (int i = 0; i < 5; i++) send_item(OP_INSERT, pick_key(), $urandom);
    for (int i = 0; i < 6; i++) send_item(OP_SCAN, '0, '0);
    send_item(OP_REMOVE, KEY_BITS'($urandom), '0);
    send_item(OP_CLEAR, '0, '0);
  endtask

  // Mostly well-formed traffic: inserts, removes of live keys, scan sweeps,
  // with some misses and the odd clear mixed in.
  task automatic test_random(input int idle_pct, input int stall_pct, input int count);
    int stop_at;
    int sel;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at        = items_sent + count;
    while (items_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 2) begin
        send_item(OP_CLEAR, KEY_BITS'($urandom), $urandom);
      end else if (sel < 8) begin
        // full sweep: scan until the table reports the end
        do send_item(OP_SCAN, KEY_BITS'($urandom), $urandom);
        while (expected_rsp[$].status != ST_END);
      end else if (sel < 45 && occupancy < LIVE_CAP) begin
        send_item(OP_INSERT, pick_key(), $urandom);
      end else if (sel < 70) begin
        send_item(OP_REMOVE, pick_live_key(), $urandom);
      end else if (sel < 78) begin
        send_item(OP_REMOVE, KEY_BITS'($urandom), $urandom);
      end else begin
        send_item(OP_SCAN, KEY_BITS'($urandom), $urandom);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    scan_ptr  = 0;
    occupancy = 0;
    waited    = 0;

    // sync reset held, then released; the block then runs its own clearing pass
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    test_full_table();
    test_random(0, 0, 150);
    test_random(78, 0, 150);
    test_random(0, 78, 150);
    test_random(8, 8, 150);

    // drain, then give the block a full walk's time to show anything extra
    release_req();
    recv_stall_pct = 0;
    while (expected_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SLOTS + 8) @(posedge clk);
    if (expected_rsp.size() != 0) begin
      $error("%0d expected results never arrived", expected_rsp.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
